FILE: rtl/wps_pkg.sv
// Package: shared constants, result codes and item types of the WAV stream parser.
package wps_pkg;

  localparam logic [31:0] IdRiff    = 32'h4646_4952;
  localparam logic [31:0] IdWave    = 32'h4556_4157;
  localparam logic [31:0] IdFmt     = 32'h2074_6D66;
  localparam logic [31:0] IdData    = 32'h6174_6164;
  localparam logic [31:0] RateReset = 32'd44100;
  localparam logic [15:0] BitsReq   = 16'd16;
  localparam logic [31:0] FmtMin    = 32'd16;

  // result queue depth, a power of two of at least 4
  localparam int unsigned ResDepth = 4;

  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindDone   = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  localparam logic [3:0] ErrRiff     = 4'd0;
  localparam logic [3:0] ErrWave     = 4'd1;
  localparam logic [3:0] ErrTag      = 4'd2;
  localparam logic [3:0] ErrRate     = 4'd3;
  localparam logic [3:0] ErrBits     = 4'd4;
  localparam logic [3:0] ErrAlign    = 4'd5;
  localparam logic [3:0] ErrChannels = 4'd6;
  localparam logic [3:0] ErrShortFmt = 4'd7;
  localparam logic [3:0] ErrMissing  = 4'd8;
  localparam logic [3:0] ErrTrunc    = 4'd9;

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [15:0]  sample;
    logic [1:0]          chan_num;
    logic [30:0]         frame_count;
    logic [3:0]          error_code;
    logic                last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

FILE: rtl/wps_byte_if.sv
// Interface: byte channel of the WAV stream parser.
interface wps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_file;

  modport source (output valid, output byte_in, output end_of_file, input ready);
  modport sink (input valid, input byte_in, input end_of_file, output ready);
endinterface

FILE: rtl/wps_res_if.sv
// Interface: result channel of the WAV stream parser.
interface wps_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample;
  logic [1:0]         chan_num;
  logic [30:0]        frame_count;
  logic [3:0]         error_code;
  logic               last_of_run;

  modport source (output valid, output kind, output sample, output chan_num,
                  output frame_count, output error_code, output last_of_run, input ready);
  modport sink (input valid, input kind, input sample, input chan_num,
                input frame_count, input error_code, input last_of_run, output ready);
endinterface

FILE: rtl/wav_pcm16_stream_parser.sv
// Top level: byte-stream WAV PCM16 parser with a result queue on its output.
// The results of an accepted byte are registered in the result queue and offered in order from its head.
// Throughput: one byte per cycle while each byte yields at most one result and out_o.ready is high;
//   the single-read result queue hands out the two results of a byte one after the other.
// in_i.ready drops while the queue holds more than two items.
// Reset clears the walk state and the queue and sets the expected rate to 44100.
module wav_pcm16_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  wps_byte_if.sink    in_i,
  wps_res_if.source   out_o
);
  import wps_pkg::*;

  push_t push;
  res_t  head;
  logic  room;
  logic  accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  wps_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (in_i.byte_in),
    .eof_i       (in_i.end_of_file),
    .push_o      (push)
  );

  wps_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .data_o  (head),
    .pop_i   (out_o.ready)
  );

  assign out_o.kind          = head.kind;
  assign out_o.sample        = head.sample;
  assign out_o.chan_num      = head.chan_num;
  assign out_o.frame_count   = head.frame_count;
  assign out_o.error_code    = head.error_code;
  assign out_o.last_of_run   = head.last_of_run;

endmodule

FILE: rtl/wps_parser.sv
// Parser core: chunk walk state, fmt checks and sample pairing, one accepted byte per cycle.
module wps_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  input  logic            eof_i,
  output wps_pkg::push_t  push_o
);
  import wps_pkg::*;

  typedef enum logic [2:0] {
    PhHdr, PhChdr, PhFmt, PhData, PhSkip, PhPad, PhHalt
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] rate_q;
  logic [31:0] rr_q, rr_d;
  logic [31:0] fs_q, fs_d;
  logic [31:0] cid_q, cid_d;
  logic [31:0] cl_q, cl_d;
  logic [4:0]  bp_q, bp_d;
  logic [1:0]  ch_q, ch_d;
  logic [31:0] db_q, db_d;
  logic        hd_q, hd_d;
  logic [7:0]  low_q, low_d;
  logic        pad_q, pad_d;

  logic [31:0] fs;
  logic [15:0] h16;
  logic        smp_vld;
  logic        term_vld;
  logic [1:0]  term_kind;
  logic [3:0]  term_err;
  logic [30:0] term_frames;
  logic        end_chunk;
  logic        bnd;
  res_t        smp_res;
  res_t        term_res;

  always_comb begin
    phase_d     = phase_q;
    rr_d        = rr_q;
    fs_d        = fs_q;
    cid_d       = cid_q;
    cl_d        = cl_q;
    bp_d        = bp_q;
    ch_d        = ch_q;
    db_d        = db_q;
    hd_d        = hd_q;
    low_d       = low_q;
    pad_d       = pad_q;
    smp_vld     = 1'b0;
    term_vld    = 1'b0;
    term_kind   = KindError;
    term_err    = ErrRiff;
    term_frames = '0;
    end_chunk   = 1'b0;
    bnd         = 1'b0;
    fs          = {byte_i, fs_q[31:8]};
    h16         = fs[31:16];

    if (accept_i && phase_q != PhHalt) begin
      fs_d = fs;
      if (phase_q != PhHdr && rr_q != 32'd0) begin
        rr_d = rr_q - 32'd1;
      end
      unique case (phase_q)
        PhHdr: begin
          bp_d = bp_q + 5'd1;
          if (bp_q == 5'd3 && fs != IdRiff) begin
            term_vld = 1'b1;
            term_err = ErrRiff;
          end else if (bp_q == 5'd7) begin
            rr_d = (fs >= 32'd4) ? fs - 32'd4 : 32'd0;
          end else if (bp_q == 5'd11) begin
            if (fs != IdWave) begin
              term_vld = 1'b1;
              term_err = ErrWave;
            end else begin
              bnd = 1'b1;
            end
          end
        end
        PhChdr: begin
          bp_d = bp_q + 5'd1;
          if (bp_q == 5'd3) begin
            cid_d = fs;
          end else if (bp_q == 5'd7) begin
            cl_d  = fs;
            pad_d = fs[0];
            bp_d  = '0;
            if (cid_q == IdFmt) begin
              if (fs < FmtMin) begin
                term_vld = 1'b1;
                term_err = ErrShortFmt;
              end else begin
                phase_d = PhFmt;
              end
            end else begin
              if (cid_q == IdData) begin
                db_d    = fs;
                hd_d    = 1'b1;
                phase_d = PhData;
              end else begin
                phase_d = PhSkip;
              end
              end_chunk = (fs == 32'd0);
            end
          end
        end
        PhPad: begin
          pad_d = 1'b0;
          bnd   = 1'b1;
        end
        PhFmt, PhData, PhSkip: begin
          cl_d = cl_q - 32'd1;
          if (phase_q == PhFmt) begin
            if (bp_q < 5'd16) begin
              bp_d = bp_q + 5'd1;
            end
            if (bp_q == 5'd1 && h16 != 16'd1) begin
              term_vld = 1'b1;
              term_err = ErrTag;
            end
            if (bp_q == 5'd3) begin
              cid_d[15:0] = h16;
            end
            if (bp_q == 5'd7 && fs != rate_q) begin
              term_vld = 1'b1;
              term_err = ErrRate;
            end
            if (bp_q == 5'd13) begin
              cid_d[31:16] = h16;
            end
            if (bp_q == 5'd15) begin
              if (h16 != BitsReq) begin
                term_vld = 1'b1;
                term_err = ErrBits;
              end else if ({1'b0, cid_q[31:16]} != {cid_q[15:0], 1'b0}) begin
                term_vld = 1'b1;
                term_err = ErrAlign;
              end else if (cid_q[15:0] != 16'd1 && cid_q[15:0] != 16'd2) begin
                term_vld = 1'b1;
                term_err = ErrChannels;
              end else begin
                ch_d = cid_q[1:0];
              end
            end
          end else if (phase_q == PhData) begin
            if (!bp_q[0]) begin
              low_d = byte_i;
            end else begin
              smp_vld = 1'b1;
            end
            bp_d = {bp_q[4:1], ~bp_q[0]};
          end
          end_chunk = !term_vld && (cl_d == 32'd0);
        end
        default: ;
      endcase

      if (end_chunk) begin
        if (pad_d) begin
          phase_d = PhPad;
        end else begin
          bnd = 1'b1;
        end
      end

      if (bnd) begin
        if (rr_d == 32'd0) begin
          term_vld = 1'b1;
          if (ch_d == 2'd0 || !hd_d || db_d == 32'd0) begin
            term_err = ErrMissing;
          end else begin
            term_kind   = KindDone;
            term_frames = (ch_d == 2'd2) ? {1'b0, db_d[31:2]} : db_d[31:1];
          end
        end else begin
          phase_d = PhChdr;
          bp_d    = '0;
        end
      end

      if (eof_i && !term_vld) begin
        term_vld = 1'b1;
        term_err = ErrTrunc;
      end

      if (term_vld) begin
        phase_d = PhHalt;
      end
    end
  end

  always_comb begin
    smp_res               = '0;
    smp_res.kind          = KindSample;
    smp_res.sample        = {byte_i, low_q};
    smp_res.last_of_run   = !term_vld;
    term_res              = '0;
    term_res.kind         = term_kind;
    term_res.last_of_run  = 1'b1;
    if (term_kind == KindDone) begin
      term_res.chan_num      = ch_d;
      term_res.frame_count   = term_frames;
    end else begin
      term_res.error_code    = term_err;
    end
    push_o.cnt = {1'b0, smp_vld} + {1'b0, term_vld};
    push_o.r0  = smp_vld ? smp_res : term_res;
    push_o.r1  = term_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHdr;
      rate_q  <= RateReset;
      rr_q    <= '0;
      fs_q    <= '0;
      cid_q   <= '0;
      cl_q    <= '0;
      bp_q    <= '0;
      ch_q    <= '0;
      db_q    <= '0;
      hd_q    <= 1'b0;
      low_q   <= '0;
      pad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      rr_q    <= rr_d;
      fs_q    <= fs_d;
      cid_q   <= cid_d;
      cl_q    <= cl_d;
      bp_q    <= bp_d;
      ch_q    <= ch_d;
      db_q    <= db_d;
      hd_q    <= hd_d;
      low_q   <= low_d;
      pad_q   <= pad_d;
    end
  end

endmodule

FILE: rtl/wps_res_fifo.sv
// Result queue: takes up to two items per cycle, hands out one per cycle while pop_i is high.
module wps_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wps_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  output wps_pkg::res_t  data_o,
  input  logic           pop_i
);
  import wps_pkg::*;

  localparam int unsigned PtrW = $clog2(ResDepth);
  localparam int unsigned CntW = $clog2(ResDepth + 1);

  res_t            mem_q [ResDepth];
  logic [PtrW-1:0] wp_q;
  logic [PtrW-1:0] rp_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign pop     = valid_o && pop_i;
  assign room_o  = (cnt_q <= CntW'(ResDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wp_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PtrW'(push_i.cnt);
      rp_q  <= rp_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(push_i.cnt) - CntW'(pop);
    end
  end

endmodule

FILE: rtl/wps_checker.sv
// Checker: port-level properties of the WAV stream parser, bound to the top level.
module wps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         kind_i,
  input logic signed [15:0] sample_i,
  input logic [30:0]        frame_count_i,
  input logic [3:0]         error_code_i,
  input logic               last_of_run_i
);
  import wps_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(sample_i)
      && $stable(frame_count_i) && $stable(error_code_i))
    else $error("result changed while stalled");

  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != KindSample |-> last_of_run_i && sample_i == 16'sd0)
    else $error("summary item not marked last or carries a sample");

  a_term_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && kind_i != KindSample |=> !out_valid_i)
    else $error("item after summary");

  a_done_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KindDone |-> error_code_i == ErrRiff)
    else $error("done item carries an error code");

endmodule

bind wav_pcm16_stream_parser wps_checker u_wps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .sample_i      (out_o.sample),
  .frame_count_i (out_o.frame_count),
  .error_code_i  (out_o.error_code),
  .last_of_run_i (out_o.last_of_run)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench: streams a randomized RIFF/WAVE file into the parser and checks each result item.
module tb_top;
  import wps_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 120;

  typedef enum logic [2:0] {PhHdr, PhChdr, PhFmt, PhData, PhSkip, PhPad, PhHalt} walk_e;
  typedef enum logic {StepByte, StepCfg} step_e;
  typedef enum logic [2:0] {EndDone, EndCross, EndTrunc, EndMissing, EndBadFmt} ending_e;
  typedef enum logic [2:0] {
    FaultTag, FaultRate, FaultBits, FaultAlign, FaultChannels, FaultShort
  } fault_e;

  typedef struct {
    step_e       op;
    logic [7:0]  b;
    logic        eof;
    logic        hold;
    logic        calm;
    logic [31:0] val;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  wps_byte_if byte_if ();
  wps_res_if  res_if ();

  wav_pcm16_stream_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (byte_if),
    .out_o       (res_if)
  );

  always #5 clk_i = ~clk_i;

  // parser state of the predictor
  walk_e       walk_ph;
  logic [31:0] riff_left;
  logic [31:0] shreg;
  logic [31:0] cid;
  logic [31:0] chunk_rem;
  logic [31:0] data_len;
  logic [31:0] rate_cfg;
  logic [4:0]  pos;
  logic [1:0]  chans;
  logic        got_data;
  logic        pad_due;
  logic [7:0]  low_b;

  res_t  byte_res_q[$];
  res_t  wav_results_q[$];
  step_t plan_q[$];
  step_t file_bytes_q[$];

  int unsigned fails;
  int unsigned n_plan_bytes;
  int unsigned n_pushed;
  int unsigned n_bytes;
  int unsigned n_samples;
  int unsigned n_cfg;
  int unsigned n_chunks;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  logic        byte_taken;
  logic        calm;
  logic        hold_kick;
  logic        hold_seen;
  logic [1:0]  end_kind;
  logic [3:0]  end_err;
  logic [31:0] plan_rate;

  function automatic void post(logic [1:0] k, logic [15:0] smp, logic [1:0] ch,
                               logic [30:0] frames, logic [3:0] err);
    res_t r;
    r = '0;
    r.kind = k;
    r.sample = smp;
    r.chan_num = ch;
    r.frame_count = frames;
    r.error_code = err;
    byte_res_q.push_back(r);
  endfunction

  function automatic void halt_with(logic [3:0] err);
    walk_ph = PhHalt;
    post(KindError, '0, '0, '0, err);
  endfunction

  function automatic void wrap_up();
    logic [31:0] frames;
    if (chans == 2'd0 || !got_data || data_len == 32'd0) begin
      halt_with(ErrMissing);
    end else begin
      frames = data_len / {29'd0, chans, 1'b0};
      walk_ph = PhHalt;
      post(KindDone, '0, chans, frames[30:0], '0);
    end
  endfunction

  function automatic void reach_boundary();
    if (riff_left == 32'd0) begin
      wrap_up();
    end else begin
      walk_ph = PhChdr;
      pos = '0;
    end
  endfunction

  function automatic void close_chunk();
    if (pad_due) walk_ph = PhPad;
    else reach_boundary();
  endfunction

  function automatic void fmt_field();
    logic [4:0]  p;
    logic [15:0] h16;
    logic [15:0] ch;
    logic [15:0] al;
    p = pos;
    h16 = shreg[31:16];
    if (p < 5'd16) pos = p + 5'd1;
    if (p == 5'd1 && h16 != 16'd1) begin
      halt_with(ErrTag);
      return;
    end
    if (p == 5'd3) cid[15:0] = h16;
    if (p == 5'd7 && shreg != rate_cfg) begin
      halt_with(ErrRate);
      return;
    end
    if (p == 5'd13) cid[31:16] = h16;
    if (p == 5'd15) begin
      ch = cid[15:0];
      al = cid[31:16];
      if (h16 != BitsReq) begin
        halt_with(ErrBits);
        return;
      end
      if ({1'b0, al} != {ch, 1'b0}) begin
        halt_with(ErrAlign);
        return;
      end
      if (ch != 16'd1 && ch != 16'd2) begin
        halt_with(ErrChannels);
        return;
      end
      chans = ch[1:0];
    end
  endfunction

  function automatic void parse_wav_byte(logic [7:0] b, logic eof);
    logic [4:0] p;
    res_t       r;
    if (walk_ph == PhHalt) return;
    byte_res_q.delete();
    shreg = {b, shreg[31:8]};
    if (walk_ph == PhHdr) begin
      p = pos;
      pos = p + 5'd1;
      if (p == 5'd3 && shreg != IdRiff) begin
        halt_with(ErrRiff);
      end else if (p == 5'd7) begin
        riff_left = (shreg >= 32'd4) ? shreg - 32'd4 : 32'd0;
      end else if (p == 5'd11) begin
        if (shreg != IdWave) halt_with(ErrWave);
        else reach_boundary();
      end
    end else begin
      if (riff_left != 32'd0) riff_left--;
      if (walk_ph == PhChdr) begin
        p = pos;
        pos = p + 5'd1;
        if (p == 5'd3) begin
          cid = shreg;
        end else if (p == 5'd7) begin
          chunk_rem = shreg;
          pad_due = shreg[0];
          pos = '0;
          if (cid == IdFmt) begin
            if (chunk_rem < FmtMin) halt_with(ErrShortFmt);
            else walk_ph = PhFmt;
          end else begin
            if (cid == IdData) begin
              data_len = chunk_rem;
              got_data = 1'b1;
              walk_ph = PhData;
            end else begin
              walk_ph = PhSkip;
            end
            if (chunk_rem == 32'd0) close_chunk();
          end
        end
      end else if (walk_ph == PhPad) begin
        pad_due = 1'b0;
        reach_boundary();
      end else begin
        chunk_rem--;
        if (walk_ph == PhFmt) begin
          fmt_field();
        end else if (walk_ph == PhData) begin
          if (!pos[0]) low_b = b;
          else post(KindSample, {b, low_b}, '0, '0, '0);
          pos[0] = ~pos[0];
        end
        if (walk_ph != PhHalt && chunk_rem == 32'd0) close_chunk();
      end
    end
    if (eof && walk_ph != PhHalt) halt_with(ErrTrunc);
    for (int i = 0; i < byte_res_q.size(); i++) begin
      r = byte_res_q[i];
      r.last_of_run = (i == byte_res_q.size() - 1);
      wav_results_q.push_back(r);
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_byte(logic [7:0] val, logic eof = 1'b0);
    step_t s;
    s = '{StepByte, val, eof, 1'b0, 1'b0, 32'd0};
    plan_q.push_back(s);
    n_plan_bytes++;
  endfunction

  function automatic void add_u16(logic [15:0] v);
    add_byte(v[7:0]);
    add_byte(v[15:8]);
  endfunction

  function automatic void add_u32(logic [31:0] v);
    add_u16(v[15:0]);
    add_u16(v[31:16]);
  endfunction

  function automatic void add_cfg(logic [31:0] v);
    step_t s;
    s = '{StepCfg, 8'd0, 1'b0, 1'b0, 1'b0, v};
    plan_q.push_back(s);
    plan_rate = v;
  endfunction

  function automatic void add_chunk_hdr(logic [31:0] id, logic [31:0] size);
    add_u32(id);
    add_u32(size);
    n_chunks++;
  endfunction

  function automatic void add_pad(int unsigned size);
    if (size % 2 == 1) add_byte(rand_byte());
  endfunction

  function automatic void add_fmt(logic [15:0] tag, logic [15:0] ch, logic [31:0] rate,
                                  logic [15:0] align, logic [15:0] bits, int unsigned size);
    add_chunk_hdr(IdFmt, size);
    add_u16(tag);
    add_u16(ch);
    add_u32(rate);
    add_u32(rate * {16'd0, align});
    add_u16(align);
    add_u16(bits);
    for (int unsigned i = 16; i < size; i++) add_byte(rand_byte());
    add_pad(size);
  endfunction

  function automatic void add_data(int unsigned size, int eof_at = -1);
    add_chunk_hdr(IdData, size);
    for (int unsigned i = 0; i < size; i++) add_byte(rand_byte(), int'(i) == eof_at);
    add_pad(size);
  endfunction

  function automatic void add_junk(int unsigned size);
    logic [31:0] tag32;
    tag32 = $urandom();
    if (tag32 == IdFmt || tag32 == IdData) tag32[0] = ~tag32[0];
    add_chunk_hdr(tag32, size);
    for (int unsigned i = 0; i < size; i++) add_byte(rand_byte());
    add_pad(size);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  // sample handshakes, predict accepted items and compare results
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni) begin
      byte_taken = byte_if.valid && byte_if.ready;
      if (byte_taken) begin
        n_bytes++;
        parse_wav_byte(byte_if.byte_in, byte_if.end_of_file);
      end
      if (res_if.valid && res_if.ready) begin
        got.kind = res_if.kind;
        got.sample = res_if.sample;
        got.chan_num = res_if.chan_num;
        got.frame_count = res_if.frame_count;
        got.error_code = res_if.error_code;
        got.last_of_run = res_if.last_of_run;
        if (got.kind == KindSample) begin
          n_samples++;
        end else begin
          end_kind = got.kind;
          end_err = got.error_code;
        end
        if (wav_results_q.size() == 0) begin
          $error("result with nothing pending: kind %0d", got.kind);
          fails++;
        end else begin
          want = wav_results_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("sample", 32'($unsigned(want.sample)), 32'($unsigned(got.sample)));
          check_field("chan_num", 32'(want.chan_num), 32'(got.chan_num));
          check_field("frame_count", 32'(want.frame_count), 32'(got.frame_count));
          check_field("error_code", 32'(want.error_code), 32'(got.error_code));
          check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        end
      end
    end
  end

  // byte sender
  always @(negedge clk_i) begin
    step_t it;
    if (!byte_if.valid || byte_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        byte_if.valid <= 1'b0;
      end else if (file_bytes_q.size() == 0) begin
        byte_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 11) - 1;
        byte_if.valid <= 1'b0;
      end else begin
        it = file_bytes_q.pop_front();
        if (it.hold) hold_kick = ~hold_kick;
        if (it.calm) calm = 1'b1;
        byte_if.valid <= 1'b1;
        byte_if.byte_in <= it.b;
        byte_if.end_of_file <= it.eof;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (hold_seen != hold_kick) begin
      hold_seen = hold_kick;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("** wav_pcm16_stream_parser: FAILED **");
    $finish;
  end

  initial begin
    ending_e     ending;
    fault_e      fault;
    logic [31:0] riff_size;
    logic [31:0] rate;
    logic [15:0] val16;
    int unsigned sel;
    int unsigned sz;
    int unsigned start;
    int unsigned idx;
    int unsigned n_fmt;
    int unsigned ch;
    logic        hold_done;
    logic        calm_done;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    byte_if.valid = 1'b0;
    byte_if.byte_in = '0;
    byte_if.end_of_file = 1'b0;
    res_if.ready = 1'b0;
    walk_ph = PhHdr;
    riff_left = '0;
    shreg = '0;
    cid = '0;
    chunk_rem = '0;
    data_len = '0;
    rate_cfg = RateReset;
    plan_rate = RateReset;
    pos = '0;
    chans = '0;
    got_data = 1'b0;
    pad_due = 1'b0;
    low_b = '0;
    byte_taken = 1'b0;
    calm = 1'b0;
    hold_kick = 1'b0;
    hold_seen = 1'b0;
    end_kind = '0;
    end_err = '0;
    hold_done = 1'b0;
    calm_done = 1'b0;
    n_fmt = 0;
    riff_size = '0;

    ending = ending_e'($urandom_range(0, 4));
    add_u32(IdRiff);
    add_u32(32'd0);
    add_u32(IdWave);

    // odd and empty skipped chunks, fmt with trailing bytes, sample extremes, odd data
    add_junk(1);
    add_junk(0);
    add_fmt(16'd1, 16'd2, RateReset, 16'd4, BitsReq, 18);
    add_chunk_hdr(IdData, 32'd5);
    add_byte(8'h00);
    add_byte(8'h80);
    add_byte(8'hff);
    add_byte(8'h7f);
    add_byte(8'h5a);
    add_byte(8'h00);
    add_data(0);

    while (n_plan_bytes < 1900) begin
      sel = $urandom_range(0, 9);
      if (!hold_done && n_plan_bytes > 700) begin
        idx = plan_q.size();
        add_data(160);
        plan_q[idx].hold = 1'b1;
        hold_done = 1'b1;
      end else if (!calm_done && n_plan_bytes > 1600) begin
        idx = plan_q.size();
        add_data($urandom_range(2, 40));
        plan_q[idx].calm = 1'b1;
        calm_done = 1'b1;
      end else if (sel == 0 || (n_fmt == 0 && n_plan_bytes > 1000)) begin
        ch = $urandom_range(1, 2);
        rate = (n_fmt == 0) ? 32'd1 : (n_fmt == 1) ? 32'hffff_ffff : $urandom();
        n_fmt++;
        add_cfg(rate);
        add_fmt(16'd1, 16'(ch), rate, 16'(2 * ch), BitsReq, 16 + $urandom_range(0, 3));
      end else if (sel <= 2) begin
        add_junk($urandom_range(0, 24));
      end else begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
        add_data(sz);
      end
    end

    start = n_plan_bytes - 12;
    case (ending)
      EndDone: begin
        sz = 2 * $urandom_range(1, 15);
        add_data(sz, $urandom_range(0, 1) ? int'(sz) - 1 : -1);
      end
      EndCross: begin
        sz = $urandom_range(3, 30);
        if ($urandom_range(0, 1)) add_data(sz);
        else add_junk(sz);
        riff_size = 4 + start + $urandom_range(1, 8 + sz + sz % 2);
      end
      EndTrunc: begin
        add_data(40, 2 * $urandom_range(0, 19) + 1);
        riff_size = 32'hffff_ffff;
      end
      EndMissing: begin
        add_data(0);
      end
      default: begin
        fault = fault_e'($urandom_range(0, 5));
        case (fault)
          FaultTag: begin
            val16 = 16'($urandom_range(0, 65535));
            if (val16 == 16'd1) val16 = 16'd0;
            add_fmt(val16, 16'd2, plan_rate, 16'd4, BitsReq, 16);
          end
          FaultRate: begin
            add_fmt(16'd1, 16'd1, plan_rate ^ (32'd1 << $urandom_range(0, 31)), 16'd2,
                    BitsReq, 16);
          end
          FaultBits: begin
            val16 = 16'($urandom_range(0, 65535));
            if (val16 == BitsReq) val16 = 16'd8;
            add_fmt(16'd1, 16'd2, plan_rate, 16'd4, val16, 16);
          end
          FaultAlign: begin
            ch = $urandom_range(1, 2);
            add_fmt(16'd1, 16'(ch), plan_rate, 16'(2 * ch) ^ (16'd1 << $urandom_range(0, 15)),
                    BitsReq, 16);
          end
          FaultChannels: begin
            ch = $urandom_range(0, 1) ? 0 : $urandom_range(3, 200);
            add_fmt(16'd1, 16'(ch), plan_rate, 16'(2 * ch), BitsReq, 16);
          end
          default: begin
            add_chunk_hdr(IdFmt, $urandom_range(0, 15));
            add_u32($urandom());
          end
        endcase
      end
    endcase
    if (ending != EndCross && ending != EndTrunc) riff_size = 4 + (n_plan_bytes - 12);
    for (int i = 0; i < 4; i++) plan_q[4 + i].b = riff_size[8 * i +: 8];

    // bytes after the final result are dropped by the parser
    add_byte(rand_byte(), 1'($urandom_range(0, 1)));
    add_byte(rand_byte(), 1'b1);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_q[i]) begin
      if (plan_q[i].op == StepCfg) begin
        while (n_bytes != n_pushed || wav_results_q.size() != 0) @(negedge clk_i);
        repeat (3) @(negedge clk_i);
        cfg_we_i <= 1'b1;
        cfg_wdata_i <= plan_q[i].val;
        rate_cfg = plan_q[i].val;
        n_cfg++;
        @(negedge clk_i);
        cfg_we_i <= 1'b0;
      end else begin
        file_bytes_q.push_back(plan_q[i]);
        n_pushed++;
      end
    end

    while (n_bytes != n_pushed || wav_results_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (wav_results_q.size() != 0) begin
      $error("%0d results never arrived", wav_results_q.size());
      fails++;
    end

    $display("Streamed %0d bytes in %0d chunks, %0d samples checked, %0d rate writes.",
             n_bytes, n_chunks, n_samples, n_cfg);
    $display("File ending %s, final result kind %0d code %0d.", ending.name(), end_kind,
             end_err);
    if (fails == 0) begin
      $display("** wav_pcm16_stream_parser: PASSED **");
    end else begin
      $display("** wav_pcm16_stream_parser: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/wps_pkg.sv
rtl/wps_byte_if.sv
rtl/wps_res_if.sv
rtl/wps_parser.sv
rtl/wps_res_fifo.sv
rtl/wav_pcm16_stream_parser.sv
rtl/wps_checker.sv
verif/tb_top.sv
